[design/msa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_pkg
// Shared constants, payload types and codes for the max distance seat
// allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int MAX_SEATS = 1024;
    localparam int IDX_W     = $clog2(MAX_SEATS);
    localparam int CNT_W     = $clog2(MAX_SEATS + 1);
    localparam int CFG_W     = 11;
    localparam int POS_W     = 10;
    localparam int WIDE_W    = CNT_W + CFG_W + POS_W;

    localparam logic [CFG_W-1:0] SEAT_COUNT_RST = CFG_W'(1024);

    localparam logic FUNC_TAKE  = 1'b0;
    localparam logic FUNC_LEAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_SEATED    = 2'd0,
        ST_LEFT      = 2'd1,
        ST_BAD_LEAVE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] seat_index;
        t_status          status;
    } t_rsp;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] n;
    } t_scan_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

endpackage

[design/msa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_cell
// One seat of the occupancy ring: holds the seat bit, takes its neighbor's
// bit on a shift and is set directly when a seat is assigned.
// ----------------------------------------------------------------------------
module msa_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_set,
    input  logic i_next,
    output logic o_occ
);
    logic r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_set) begin
            r_occ <= 1'b1;
        end else if (i_shift) begin
            r_occ <= i_next;
        end
    end

    assign o_occ = r_occ;

endmodule

[design/msa_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msa_scan
// Gap tracker: follows the occupied seats leaving the ring head one per
// cycle and keeps the widest gap found so far and its seat.
// ----------------------------------------------------------------------------
module msa_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  msa_pkg::t_scan_ctl        i_ctl,
    output logic                      o_found,
    output logic [msa_pkg::IDX_W-1:0] o_pick
);
    import msa_pkg::*;

    logic             r_any;
    logic [IDX_W-1:0] r_prev;
    logic [IDX_W-1:0] r_best;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] gap;
    logic [CNT_W-1:0] last;
    logic [CNT_W-1:0] tail;
    logic [CNT_W-1:0] best_fin;
    logic [IDX_W-1:0] pos_fin;

    assign gap = (i_ctl.idx - r_prev) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_ctl.clear) begin
            r_any <= 1'b0;
        end else if (i_ctl.step) begin
            r_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_prev <= i_ctl.idx;
            if (!r_any) begin
                r_best <= i_ctl.idx;
                r_pos  <= '0;
            end else if (gap > r_best) begin
                r_best <= gap;
                r_pos  <= r_prev + gap;
            end
        end
    end

    // closing gap up to the last seat in use
    assign last = i_ctl.n - CNT_W'(1);
    assign tail = last - CNT_W'(r_prev);

    always_comb begin
        if (tail > CNT_W'(r_best)) begin
            best_fin = tail;
            pos_fin  = last[IDX_W-1:0];
        end else begin
            best_fin = CNT_W'(r_best);
            pos_fin  = r_pos;
        end
    end

    assign o_found = !r_any || (best_fin != '0);
    assign o_pick  = r_any ? pos_fin : '0;

endmodule

[design/max_distance_seat_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_distance_seat_allocator
// Occupancy map over a row of seats; take requests get the seat farthest
// from any occupied seat, leave requests free one seat.
// ----------------------------------------------------------------------------
// Every transaction, take or leave, runs the same way: the occupancy map is a
// ring of MAX_SEATS one-bit cells that rotates once through the gap tracker,
// one seat per cycle, followed by a finish state that picks the seat and
// writes it back. busy stays high from the accepting edge until the result
// strobe, and a new start is taken in the cycle the result is shown.
// o_result_valid is high for exactly one cycle per transaction and cannot be
// held off, so the receiver must take each result when it appears.
// seat_count may only be written while busy is low.
module max_distance_seat_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  msa_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [msa_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_result_valid,
    output msa_pkg::t_rsp             o_rsp
);
    import msa_pkg::*;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    t_req             r_req;
    t_rsp             r_rsp;
    logic             r_valid;
    logic             r_hit;
    logic [IDX_W-1:0] r_pick;
    logic [CFG_W-1:0] r_seat_count;

    logic [WIDE_W-1:0]    cfg_wide;
    logic [WIDE_W-1:0]    n_wide;
    logic [CNT_W-1:0]     n_use;
    logic [WIDE_W-1:0]    idx_wide;
    logic [WIDE_W-1:0]    pick_wide;
    logic                 in_use;
    logic                 accept;
    logic                 shift;
    logic                 head;
    logic                 leave_clr;
    logic                 take_set;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [MAX_SEATS-1:0] occ;
    t_scan_ctl            scan_ctl;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= SEAT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_seat_count <= i_cfg_wdata;
        end
    end

    // seats in use, saturated to 1..MAX_SEATS
    assign cfg_wide = WIDE_W'(r_seat_count);
    always_comb begin
        if (cfg_wide == '0) begin
            n_wide = WIDE_W'(1);
        end else if (cfg_wide > WIDE_W'(MAX_SEATS)) begin
            n_wide = WIDE_W'(MAX_SEATS);
        end else begin
            n_wide = cfg_wide;
        end
    end
    assign n_use = n_wide[CNT_W-1:0];

    assign idx_wide  = WIDE_W'(r_idx);
    assign in_use    = idx_wide < n_wide;
    assign shift     = (r_state == S_SCAN);
    assign head      = occ[0];
    assign leave_clr = shift && (r_req.func == FUNC_LEAVE) && in_use && head
                       && (idx_wide == WIDE_W'(r_req.position));
    assign take_set  = (r_state == S_FIN) && (r_req.func == FUNC_TAKE) && found;

    genvar k;
    generate
        for (k = 0; k < MAX_SEATS; k++) begin : g_ring
            logic nb;
            if (k == MAX_SEATS - 1) begin : g_wrap
                assign nb = head && !leave_clr;
            end else begin : g_link
                assign nb = occ[k+1];
            end
            msa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_set   (take_set && (pick == IDX_W'(k))),
                .i_next  (nb),
                .o_occ   (occ[k])
            );
        end
    endgenerate

    assign scan_ctl.clear = accept;
    assign scan_ctl.step  = shift && in_use && head && (r_req.func == FUNC_TAKE);
    assign scan_ctl.idx   = r_idx;
    assign scan_ctl.n     = n_use;

    msa_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .o_found (found),
        .o_pick  (pick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (leave_clr) begin
                        r_hit <= 1'b1;
                    end
                    if (r_idx == IDX_W'(MAX_SEATS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign pick_wide = WIDE_W'(pick);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == S_FIN) begin
            r_pick <= pick;
            if (r_req.func == FUNC_TAKE) begin
                if (found) begin
                    r_rsp.seat_index <= pick_wide[POS_W-1:0];
                    r_rsp.status     <= ST_SEATED;
                end else begin
                    r_rsp.seat_index <= '0;
                    r_rsp.status     <= ST_FULL;
                end
            end else begin
                r_rsp.seat_index <= r_req.position;
                r_rsp.status     <= r_hit ? ST_LEFT : ST_BAD_LEAVE;
            end
        end
    end

    assign o_result_valid = r_valid;
    assign o_rsp          = r_rsp;

    // ring returns to its home alignment whenever the block is idle
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_idx == '0))
        else $error("scan index not home while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_FIN))
        else $error("result strobe without finish cycle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_seat_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_rsp.status == ST_SEATED)) |-> occ[r_pick])
        else $error("assigned seat not marked occupied");

endmodule

[tb/tb_max_distance_seat_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_distance_seat_allocator
// Self-checking bench for the seat allocator: a scoreboard keeps its own
// occupancy map and predicts each seat assignment or release, while tasks
// drive take and leave transactions across a range of row sizes, with
// random gaps, and check every result strobe in order.
// ----------------------------------------------------------------------------
module tb_max_distance_seat_allocator;

    import msa_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RANDOM_ITEMS = 580;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = MAX_SEATS + 80;

    class seat_map_scoreboard;
        bit [MAX_SEATS-1:0] occupied;
        logic [CFG_W-1:0]   seat_cfg;
        t_rsp               awaited_rsp[$];
        int                 errors;

        function new();
            occupied = '0;
            seat_cfg = SEAT_COUNT_RST;
            errors   = 0;
        endfunction

        function void set_seat_count(logic [CFG_W-1:0] v);
            seat_cfg = v;
        endfunction

        function int seats_in_use();
            int n;
            n = seat_cfg;
            if (n < 1) n = 1;
            if (n > MAX_SEATS) n = MAX_SEATS;
            return n;
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        // random occupied seat below the active count, if any
        function bit pick_taken_seat(output logic [POS_W-1:0] seat);
            int taken[$];
            int n;
            n = seats_in_use();
            seat = '0;
            for (int i = 0; i < n; i++) begin
                if (occupied[i]) taken.push_back(i);
            end
            if (taken.size() == 0) return 1'b0;
            seat = POS_W'(taken[$urandom_range(0, taken.size() - 1)]);
            return 1'b1;
        endfunction

        // widest-gap seat choice and release, updating the map
        function t_rsp allot_seat(t_req req);
            t_rsp rsp;
            int   n;
            int   prev;
            int   best;
            int   spot;
            int   d;
            bit   any;
            n    = seats_in_use();
            prev = 0;
            best = 0;
            spot = 0;
            any  = 1'b0;
            if (req.func == FUNC_TAKE) begin
                for (int i = 0; i < n; i++) begin
                    if (occupied[i]) begin
                        if (!any) begin
                            best = i;
                            spot = 0;
                            any  = 1'b1;
                        end else begin
                            d = (i - prev) / 2;
                            if (d > best) begin
                                best = d;
                                spot = prev + d;
                            end
                        end
                        prev = i;
                    end
                end
                if (any && (n - 1 - prev > best)) begin
                    best = n - 1 - prev;
                    spot = n - 1;
                end
                if (any && best == 0) begin
                    rsp.seat_index = '0;
                    rsp.status     = ST_FULL;
                end else begin
                    occupied[spot] = 1'b1;
                    rsp.seat_index = POS_W'(spot);
                    rsp.status     = ST_SEATED;
                end
            end else begin
                rsp.seat_index = req.position;
                if (int'(req.position) < n && occupied[req.position]) begin
                    occupied[req.position] = 1'b0;
                    rsp.status = ST_LEFT;
                end else begin
                    rsp.status = ST_BAD_LEAVE;
                end
            end
            return rsp;
        endfunction

        function void note_request(t_req req);
            awaited_rsp.push_back(allot_seat(req));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_rsp rsp);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                report_mismatch("unexpected result, seat_index", rsp.seat_index, -1);
            end else begin
                want = awaited_rsp.pop_front();
                if (rsp.seat_index !== want.seat_index)
                    report_mismatch("seat_index", rsp.seat_index, want.seat_index);
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             o_result_valid;
    t_rsp             o_rsp;

    seat_map_scoreboard sb;
    int unsigned        cycles;

    max_distance_seat_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_rsp          (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result check first, then the transaction accepted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) sb.check_result(o_rsp);
            if (start && !busy) sb.note_request(i_req);
        end
    end

    task send_req(logic f, logic [POS_W-1:0] p);
        @(negedge i_clk);
        start          <= 1'b1;
        i_req.func     <= f;
        i_req.position <= p;
        do @(posedge i_clk); while (busy);
    endtask

    task idle_sender(int k);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (k - 1) @(negedge i_clk);
    endtask

    task wait_all_seated();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() > 0 || busy) @(posedge i_clk);
    endtask

    task write_seat_count(logic [CFG_W-1:0] v);
        wait_all_seated();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_seat_count(v);
    endtask

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(5, MAX_SEATS + 300);
    endfunction

    initial begin
        logic [CFG_W-1:0] row_sizes[14];
        logic [POS_W-1:0] p;
        logic             f;
        int               sent;
        int               phase;
        int               phase_items;
        int               take_pct;
        int               gap;
        int               r;
        bit               quiet;

        row_sizes = '{11'd2, 11'd3, 11'd7, 11'd16, 11'd1024, 11'd5, 11'd0,
                      11'd40, 11'd2047, 11'd1, 11'd100, 11'd12, 11'd1025, 11'd64};
        sb          = new();
        cycles      = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty row, ends of the row, midpoints, bad leaves
        send_req(FUNC_TAKE, 10'h3FF);
        send_req(FUNC_TAKE, 10'h000);
        send_req(FUNC_TAKE, 10'h155);
        send_req(FUNC_TAKE, 10'h2AA);
        send_req(FUNC_LEAVE, 10'd5);
        send_req(FUNC_LEAVE, 10'd0);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_LEAVE, 10'h3FF);
        send_req(FUNC_LEAVE, 10'h3FF);
        send_req(FUNC_TAKE, 10'd0);

        // single seat: full row, leave out of range
        write_seat_count(11'd1);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_LEAVE, 10'd1);
        send_req(FUNC_LEAVE, 10'd0);
        send_req(FUNC_TAKE, 10'h3FF);

        // zero count behaves as one seat
        write_seat_count(11'd0);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_LEAVE, 10'd0);

        // oversized count saturates
        write_seat_count(11'h7FF);
        send_req(FUNC_LEAVE, 10'h3FF);
        send_req(FUNC_TAKE, 10'd0);

        // shrunk row with seats still held beyond the count
        write_seat_count(11'd3);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_TAKE, 10'd0);
        send_req(FUNC_LEAVE, 10'd2);
        send_req(FUNC_LEAVE, 10'h3FE);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_seat_count(row_sizes[phase % 14]);
            phase_items = $urandom_range(25, 50);
            take_pct    = $urandom_range(45, 90);
            quiet       = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < take_pct) begin
                    f = FUNC_TAKE;
                    p = POS_W'($urandom_range(0, MAX_SEATS - 1));
                end else begin
                    f = FUNC_LEAVE;
                    if ($urandom_range(0, 9) < 2 || !sb.pick_taken_seat(p)) begin
                        if ($urandom_range(0, 1))
                            p = POS_W'($urandom_range(0, MAX_SEATS - 1));
                        else
                            p = POS_W'($urandom_range(0, sb.seats_in_use() - 1));
                    end
                end
                send_req(f, p);
                sent++;
                gap = quiet ? 0 : pick_gap();
                if (gap > 0) idle_sender(gap);
            end
            phase++;
        end

        wait_all_seated();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
